FILE: rtl/assert_macros.svh
// Assertion macros used by rtl/huffman_bit_decoder.sv.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

// Checked on every rising edge of clk_i, suspended while rst_ni is low.
`define ASSERT_RST(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Checked on every rising edge of clk_i, reset included.
`define ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`else

`define ASSERT_RST(lbl, prop, msg)
`define ASSERT_ALWAYS(lbl, prop, msg)

`endif

`endif

FILE: rtl/hbd_pkg.sv
package hbd_pkg;

  localparam int MaxCodeLenDef = 16;
  localparam int NumSymbolsDef = 256;

  localparam int CmdW    = 2;
  localparam int SymbolW = 8;
  localparam int CodeW   = 16;
  localparam int LenW    = 5;
  localparam int KindW   = 2;

  typedef enum logic [CmdW-1:0] {
    CmdLoad  = 2'd0,
    CmdBit   = 2'd1,
    CmdFlush = 2'd2
  } cmd_e;

  typedef enum logic [KindW-1:0] {
    KindSymbol   = 2'd0,
    KindFlush    = 2'd1,
    KindOverflow = 2'd2
  } kind_e;

  typedef enum logic [1:0] {
    StIdle,
    StScan,
    StEmit
  } state_e;

  typedef struct packed {
    logic [CodeW-1:0] code;
    logic [LenW-1:0]  len;
  } tbl_entry_t;

  typedef struct packed {
    kind_e              kind;
    logic [SymbolW-1:0] symbol_out;
    logic [LenW-1:0]    dropped_bits;
  } out_item_t;

endpackage

FILE: rtl/hbd_in_if.sv
interface hbd_in_if;
  import hbd_pkg::*;

  logic               valid;
  logic               ready;
  logic [CmdW-1:0]    cmd;
  logic [SymbolW-1:0] symbol;
  logic [CodeW-1:0]   code_value;
  logic [LenW-1:0]    code_len;
  logic               bit_in;

  modport source (
    output valid, cmd, symbol, code_value, code_len, bit_in,
    input  ready
  );

  modport sink (
    input  valid, cmd, symbol, code_value, code_len, bit_in,
    output ready
  );
endinterface

FILE: rtl/hbd_out_if.sv
interface hbd_out_if;
  import hbd_pkg::*;

  logic               valid;
  logic               ready;
  logic [KindW-1:0]   kind;
  logic [SymbolW-1:0] symbol_out;
  logic [LenW-1:0]    dropped_bits;

  modport source (
    output valid, kind, symbol_out, dropped_bits,
    input  ready
  );

  modport sink (
    input  valid, kind, symbol_out, dropped_bits,
    output ready
  );
endinterface

FILE: rtl/hbd_table.sv
module hbd_table #(
  parameter int  NumSymbols = hbd_pkg::NumSymbolsDef,
  localparam int SymW       = (NumSymbols > 1) ? $clog2(NumSymbols) : 1
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                we_i,
  input  logic [SymW-1:0]     waddr_i,
  input  hbd_pkg::tbl_entry_t wentry_i,
  input  logic                re_i,
  input  logic [SymW-1:0]     raddr_i,
  output hbd_pkg::tbl_entry_t rentry_o
);
  import hbd_pkg::*;

  tbl_entry_t mem_q [NumSymbols];
  logic [NumSymbols-1:0] vld_q;
  tbl_entry_t rdata_q;
  logic       rvld_q;

  // written entries only; an unwritten entry reads as length zero
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (we_i) begin
      vld_q[waddr_i] <= 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rvld_q <= 1'b0;
    end else if (re_i) begin
      rvld_q <= vld_q[raddr_i];
    end
  end

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wentry_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  always_comb begin
    rentry_o     = rdata_q;
    rentry_o.len = rvld_q ? rdata_q.len : '0;
  end

endmodule

FILE: rtl/huffman_bit_decoder.sv
// Channel  Dir  Transfer carries
// in_i     in   cmd, symbol, code_value, code_len, bit_in
// out_o    out  kind, symbol_out, dropped_bits
//
// Load and unused commands are taken in the idle state; a flush goes through the emit state to the output register.
// A bit is handled in the scan state: the table is scanned one entry per cycle
// through its single read port, stopping at the first hit.
// Reset clears the length valid bits at once; there is no clearing pass.
// A result waits in the emit state while the output register is still full;
// in_i is ready only between items.
`include "assert_macros.svh"

module huffman_bit_decoder #(
  parameter int MaxCodeLen = hbd_pkg::MaxCodeLenDef,
  parameter int NumSymbols = hbd_pkg::NumSymbolsDef
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  hbd_in_if.sink           in_i,
  hbd_out_if.source        out_o
);
  import hbd_pkg::*;

  localparam int SymW     = (NumSymbols > 1) ? $clog2(NumSymbols) : 1;
  localparam int AccW     = MaxCodeLen;
  localparam int CntW     = $clog2(MaxCodeLen + 1);
  localparam int LenCmpW  = (CntW > LenW) ? CntW : LenW;
  localparam int CodeCmpW = (AccW > CodeW) ? AccW : CodeW;
  localparam int SymCmpW  = SymbolW + 1;
  localparam int LenLimW  = LenW + 1;

  state_e state_q, state_d;
  logic [AccW-1:0] acc_q, acc_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic [SymW-1:0] idx_q, idx_d;
  out_item_t       res_q, res_d;
  out_item_t       out_q, out_d;
  logic            out_valid_q, out_valid_d;

  logic            in_xfer, out_free, last, hit;
  logic            tbl_we, tbl_re;
  logic [SymW-1:0] tbl_raddr;
  tbl_entry_t      tbl_wentry, tbl_rentry;
  logic [CodeW:0]  len_mask;
  logic            load_ok;

  assign in_i.ready = (state_q == StIdle);
  assign in_xfer    = in_i.valid && in_i.ready;
  assign out_free   = !out_valid_q || out_o.ready;
  assign last       = (idx_q == SymW'(NumSymbols - 1));

  assign hit = (tbl_rentry.len != '0)
            && (LenCmpW'(tbl_rentry.len) == LenCmpW'(cnt_q))
            && (CodeCmpW'(tbl_rentry.code) == CodeCmpW'(acc_q));

  assign len_mask = ((CodeW + 1)'(1) << in_i.code_len) - (CodeW + 1)'(1);
  assign load_ok  = (SymCmpW'(in_i.symbol) < SymCmpW'(NumSymbols))
                 && (LenLimW'(in_i.code_len) <= LenLimW'(MaxCodeLen));

  assign tbl_we          = in_xfer && (in_i.cmd == CmdLoad) && load_ok;
  assign tbl_wentry.code = in_i.code_value & len_mask[CodeW-1:0];
  assign tbl_wentry.len  = in_i.code_len;

  hbd_table #(
    .NumSymbols (NumSymbols)
  ) u_table (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .we_i     (tbl_we),
    .waddr_i  (in_i.symbol[SymW-1:0]),
    .wentry_i (tbl_wentry),
    .re_i     (tbl_re),
    .raddr_i  (tbl_raddr),
    .rentry_o (tbl_rentry)
  );

  always_comb begin
    state_d = state_q;
    case (state_q)
      StIdle: begin
        if (in_xfer && (in_i.cmd == CmdBit)) begin
          state_d = StScan;
        end else if (in_xfer && (in_i.cmd == CmdFlush)) begin
          state_d = StEmit;
        end
      end
      StScan: begin
        if (hit || (last && (cnt_q >= CntW'(MaxCodeLen)))) begin
          state_d = StEmit;
        end else if (last) begin
          state_d = StIdle;
        end
      end
      StEmit: begin
        if (out_free) begin
          state_d = StIdle;
        end
      end
      default: state_d = StIdle;
    endcase
  end

  always_comb begin
    acc_d       = acc_q;
    cnt_d       = cnt_q;
    idx_d       = idx_q;
    res_d       = res_q;
    out_d       = out_q;
    out_valid_d = out_valid_q && !out_o.ready;
    tbl_re      = 1'b0;
    tbl_raddr   = idx_q + SymW'(1);
    case (state_q)
      StIdle: begin
        if (in_xfer && (in_i.cmd == CmdBit)) begin
          acc_d     = {acc_q[AccW-2:0], in_i.bit_in};
          cnt_d     = cnt_q + CntW'(1);
          idx_d     = '0;
          tbl_re    = 1'b1;
          tbl_raddr = '0;
        end else if (in_xfer && (in_i.cmd == CmdFlush)) begin
          res_d.kind         = KindFlush;
          res_d.symbol_out   = '0;
          res_d.dropped_bits = LenW'(cnt_q);
          acc_d              = '0;
          cnt_d              = '0;
        end
      end
      StScan: begin
        if (hit) begin
          res_d.kind         = KindSymbol;
          res_d.symbol_out   = SymbolW'(idx_q);
          res_d.dropped_bits = '0;
          acc_d              = '0;
          cnt_d              = '0;
        end else if (last) begin
          if (cnt_q >= CntW'(MaxCodeLen)) begin
            res_d.kind         = KindOverflow;
            res_d.symbol_out   = '0;
            res_d.dropped_bits = LenW'(cnt_q);
            acc_d              = '0;
            cnt_d              = '0;
          end
        end else begin
          tbl_re = 1'b1;
          idx_d  = idx_q + SymW'(1);
        end
      end
      StEmit: begin
        if (out_free) begin
          out_d       = res_q;
          out_valid_d = 1'b1;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      acc_q       <= '0;
      cnt_q       <= '0;
      idx_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      acc_q       <= acc_d;
      cnt_q       <= cnt_d;
      idx_q       <= idx_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    res_q <= res_d;
    out_q <= out_d;
  end

  assign out_o.valid        = out_valid_q;
  assign out_o.kind         = out_q.kind;
  assign out_o.symbol_out   = out_q.symbol_out;
  assign out_o.dropped_bits = out_q.dropped_bits;

  `ASSERT_ALWAYS(a_cnt_bound, !rst_ni || (cnt_q <= CntW'(MaxCodeLen)), "bit count too high")
  `ASSERT_RST(a_bit_scan, in_xfer && (in_i.cmd == CmdBit) |=> state_q == StScan, "bit not scanned")
  `ASSERT_RST(a_hit_clear, (state_q == StScan) && hit |=> cnt_q == '0, "count kept after hit")
  `ASSERT_RST(a_sym_drop, out_valid_q && (out_q.kind == KindSymbol) |-> out_q.dropped_bits == '0, "symbol with dropped bits")

endmodule

FILE: sim/tb.sv
`timescale 1ns / 100ps

module tb;
  import hbd_pkg::*;

  localparam logic [CmdW-1:0] CmdUnused = 2'd3;
  localparam int WatchdogLimit = 4000;
  localparam int TailCycles    = 300;
  localparam int RandomItems   = 580;

  typedef struct {
    logic [CmdW-1:0]    cmd;
    logic [SymbolW-1:0] symbol;
    logic [CodeW-1:0]   code_value;
    logic [LenW-1:0]    code_len;
    logic               bit_in;
    bit                 drain;
  } dec_item_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  hbd_in_if  in_if();
  hbd_out_if out_if();

  huffman_bit_decoder dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (in_if),
    .out_o (out_if)
  );

  always #2 clk_i = ~clk_i;

  dec_item_t  pending_items[$];
  out_item_t  expected_results[$];

  // predictor state
  logic [CodeW-1:0] code_tbl[NumSymbolsDef];
  logic [LenW-1:0]  len_tbl[NumSymbolsDef];
  logic [CodeW-1:0] acc_bits;
  logic [LenW-1:0]  acc_cnt;

  // table as seen while building stimulus
  logic [CodeW-1:0] gen_code[NumSymbolsDef];
  logic [LenW-1:0]  gen_len[NumSymbolsDef];

  bit hold_next;
  bit in_took;
  int sent_cnt;
  int fail_cnt;
  int idle_cyc;

  wire quiet = (sent_cnt >= 250) && (sent_cnt < 360);

  function automatic bit decode_step(input dec_item_t req, output out_item_t res);
    res = '{kind: KindSymbol, symbol_out: '0, dropped_bits: '0};
    case (req.cmd)
      CmdLoad: begin
        if (req.code_len <= MaxCodeLenDef) begin
          len_tbl[req.symbol]  = req.code_len;
          code_tbl[req.symbol] = req.code_value & ~(16'hFFFF << req.code_len);
        end
        return 1'b0;
      end
      CmdBit: begin
        acc_bits = {acc_bits[CodeW-2:0], req.bit_in};
        acc_cnt  = acc_cnt + 1'b1;
        for (int i = 0; i < NumSymbolsDef; i++) begin
          if (len_tbl[i] != '0 && len_tbl[i] == acc_cnt && code_tbl[i] == acc_bits) begin
            res.symbol_out = SymbolW'(i);
            acc_bits = '0;
            acc_cnt  = '0;
            return 1'b1;
          end
        end
        if (acc_cnt >= MaxCodeLenDef) begin
          res.kind         = KindOverflow;
          res.dropped_bits = acc_cnt;
          acc_bits = '0;
          acc_cnt  = '0;
          return 1'b1;
        end
        return 1'b0;
      end
      CmdFlush: begin
        res.kind         = KindFlush;
        res.dropped_bits = acc_cnt;
        acc_bits = '0;
        acc_cnt  = '0;
        return 1'b1;
      end
      default: return 1'b0;
    endcase
  endfunction

  task automatic push_item(input logic [CmdW-1:0] cmd, input int sym, input int val,
                           input int len, input int b);
    dec_item_t it;
    it = '{cmd: cmd, symbol: SymbolW'(sym), code_value: CodeW'(val),
           code_len: LenW'(len), bit_in: b[0], drain: hold_next};
    hold_next = 1'b0;
    if (cmd == CmdLoad && it.code_len <= MaxCodeLenDef) begin
      gen_len[it.symbol]  = it.code_len;
      gen_code[it.symbol] = it.code_value & ~(16'hFFFF << it.code_len);
    end
    pending_items.insert(pending_items.size(), it);
  endtask

  task automatic push_code(input int sym);
    for (int k = gen_len[sym] - 1; k >= 0; k--)
      push_item(CmdBit, $urandom, $urandom, $urandom, int'(gen_code[sym][k]));
  endtask

  // stimulus
  initial begin
    int live[$];
    int r;
    int n;
    int sym;
    int len;
    int done_cnt;
    in_if.valid      = 1'b0;
    in_if.cmd        = CmdLoad;
    in_if.symbol     = '0;
    in_if.code_value = '0;
    in_if.code_len   = '0;
    in_if.bit_in     = 1'b0;
    out_if.ready     = 1'b0;
    for (int i = 0; i < NumSymbolsDef; i++) begin
      gen_len[i]  = '0;
      gen_code[i] = '0;
    end

    // directed
    push_item(CmdFlush, 0, 0, 0, 0);
    push_item(CmdUnused, $urandom, $urandom, $urandom, 1);
    push_item(CmdLoad, 255, 16'hFFFF, 16, 1);
    push_item(CmdLoad, 0, 16'h0000, 16, 0);
    push_item(CmdLoad, 10, 16'hFFFF, 2, 0);   // code wider than its length
    push_item(CmdLoad, 5, 16'h0003, 2, 0);    // same code, lower symbol wins
    push_item(CmdLoad, 3, 16'h1234, 17, 0);   // too long, ignored
    push_item(CmdLoad, 7, 16'h5555, 31, 0);
    push_item(CmdBit, 0, 0, 0, 1);
    push_item(CmdBit, 0, 0, 0, 1);
    push_item(CmdLoad, 5, 16'h0000, 0, 0);    // remove
    push_item(CmdBit, 0, 0, 0, 0);
    push_item(CmdLoad, 20, 16'hFFFD, 2, 0);   // load in the middle of a code
    push_item(CmdBit, 0, 0, 0, 1);
    push_item(CmdBit, 0, 0, 0, 1);
    push_item(CmdBit, 0, 0, 0, 1);
    push_item(CmdBit, 0, 0, 0, 1);
    push_item(CmdBit, 0, 0, 0, 0);
    push_item(CmdFlush, 0, 0, 0, 0);

    // random
    hold_next = 1'b1;
    done_cnt = 0;
    while (done_cnt < RandomItems) begin
      if (done_cnt > 300 && done_cnt < 320) hold_next = 1'b1;
      live.delete();
      for (int i = 0; i < NumSymbolsDef; i++)
        if (gen_len[i] != '0) live.insert(live.size(), i);
      r = $urandom_range(99);
      if (live.size() < 2 || r < 10) begin
        if (live.size() > 12 && $urandom_range(5) == 0) begin
          foreach (live[i]) push_item(CmdLoad, live[i], $urandom, 0, $urandom);
          done_cnt += live.size();
          live.delete();
        end
        n = $urandom_range(1, 4);
        repeat (n) begin
          r = $urandom_range(99);
          sym = ($urandom_range(1) == 0) ? $urandom_range(0, 15) : $urandom_range(0, 255);
          if (r < 60)      len = $urandom_range(1, 6);
          else if (r < 72) len = $urandom_range(7, 16);
          else if (r < 85) begin
            len = 0;
            if (live.size() != 0) sym = live[$urandom_range(0, live.size() - 1)];
          end else len = $urandom_range(17, 31);
          push_item(CmdLoad, sym, $urandom, len, $urandom);
          done_cnt++;
        end
      end else if (r < 70) begin
        sym = live[$urandom_range(0, live.size() - 1)];
        push_code(sym);
        done_cnt += gen_len[sym];
      end else if (r < 85) begin
        n = $urandom_range(1, 18);
        repeat (n) push_item(CmdBit, $urandom, $urandom, $urandom, $urandom);
        done_cnt += n;
      end else if (r < 95) begin
        push_item(CmdFlush, $urandom, $urandom, $urandom, $urandom);
        done_cnt++;
      end else begin
        push_item(CmdUnused, $urandom, $urandom, $urandom, $urandom);
      end
    end
    push_item(CmdFlush, 0, 0, 0, 0);

    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    while (pending_items.size() != 0 || in_if.valid) @(posedge clk_i);
    while (expected_results.size() != 0) @(posedge clk_i);
    repeat (TailCycles) @(posedge clk_i);
    if (fail_cnt == 0) begin
      $display("huffman_bit_decoder test passed");
    end else begin
      $display("huffman_bit_decoder test failed");
    end
    $finish;
  end

  // driver
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      in_if.valid  <= 1'b0;
      out_if.ready <= 1'b0;
    end else begin
      out_if.ready <= quiet ? 1'b1 : ($urandom_range(99) >= 16);
      if (!in_if.valid || in_took) begin
        if (pending_items.size() != 0 && (quiet || $urandom_range(99) >= 16) &&
            !(pending_items[0].drain && expected_results.size() != 0)) begin
          in_if.cmd        <= pending_items[0].cmd;
          in_if.symbol     <= pending_items[0].symbol;
          in_if.code_value <= pending_items[0].code_value;
          in_if.code_len   <= pending_items[0].code_len;
          in_if.bit_in     <= pending_items[0].bit_in;
          in_if.valid      <= 1'b1;
          pending_items.delete(0);
        end else begin
          in_if.valid <= 1'b0;
        end
      end
    end
  end

  // monitor and checker
  always @(posedge clk_i or negedge rst_ni) begin
    dec_item_t  req;
    out_item_t  res;
    out_item_t  exp_res;
    if (!rst_ni) begin
      in_took  <= 1'b0;
      sent_cnt <= 0;
      acc_bits = '0;
      acc_cnt  = '0;
      for (int i = 0; i < NumSymbolsDef; i++) begin
        len_tbl[i]  = '0;
        code_tbl[i] = '0;
      end
    end else begin
      if (out_if.valid && out_if.ready) begin
        if (expected_results.size() == 0) begin
          $error("unexpected result kind=%0d symbol_out=%0d dropped_bits=%0d",
                 out_if.kind, out_if.symbol_out, out_if.dropped_bits);
          fail_cnt++;
        end else begin
          exp_res = expected_results[0];
          expected_results.delete(0);
          if (out_if.kind !== exp_res.kind) begin
            $error("kind: expected %0d, got %0d", exp_res.kind, out_if.kind);
            fail_cnt++;
          end
          if (out_if.symbol_out !== exp_res.symbol_out) begin
            $error("symbol_out: expected %0d, got %0d", exp_res.symbol_out, out_if.symbol_out);
            fail_cnt++;
          end
          if (out_if.dropped_bits !== exp_res.dropped_bits) begin
            $error("dropped_bits: expected %0d, got %0d",
                   exp_res.dropped_bits, out_if.dropped_bits);
            fail_cnt++;
          end
        end
      end
      in_took <= in_if.valid && in_if.ready;
      if (in_if.valid && in_if.ready) begin
        req = '{cmd: in_if.cmd, symbol: in_if.symbol, code_value: in_if.code_value,
                code_len: in_if.code_len, bit_in: in_if.bit_in, drain: 1'b0};
        if (decode_step(req, res)) expected_results.insert(expected_results.size(), res);
        sent_cnt <= sent_cnt + 1;
      end
    end
  end

  // watchdog: cycles without any transfer
  always @(posedge clk_i) begin
    if (!rst_ni || (in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) begin
      idle_cyc <= 0;
    end else if (idle_cyc >= WatchdogLimit) begin
      $display("huffman_bit_decoder test failed");
      $finish;
    end else begin
      idle_cyc <= idle_cyc + 1;
    end
  end

endmodule
